FILE: rtl/barad_pkg.sv
// Package with shared widths, codes and types of the bus address range decoder.
`timescale 1ns / 1ps
package barad_pkg;

  localparam int ADDR_W = 64;
  localparam int DEV_W  = 4;
  localparam int DATA_W = 8;
  localparam int STAT_W = 2;

  // Request command codes
  localparam logic CMD_ATTACH = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  // Response status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERLAP = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  // Result of the shared range compare unit
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] diff;
  } cmp_out_t;

endpackage

FILE: rtl/barad_req_if.sv
// Request and response channel interfaces of the bus address range decoder.
`timescale 1ns / 1ps
interface barad_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [barad_pkg::ADDR_W-1:0] address;
  logic [barad_pkg::ADDR_W-1:0] range_last;
  logic                         is_write;
  logic [barad_pkg::DATA_W-1:0] write_data;

  modport source (output valid, cmd, address, range_last, is_write, write_data,
                  input ready);
  modport sink (input valid, cmd, address, range_last, is_write, write_data,
                output ready);
endinterface

interface barad_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [barad_pkg::STAT_W-1:0] status;
  logic [barad_pkg::DEV_W-1:0]  device_index;
  logic [barad_pkg::ADDR_W-1:0] offset;
  logic                         write_strobe;
  logic [barad_pkg::DATA_W-1:0] data_out;

  modport source (output valid, status, device_index, offset, write_strobe, data_out,
                  input ready);
  modport sink (input valid, status, device_index, offset, write_strobe, data_out,
                output ready);
endinterface

FILE: rtl/barad_table.sv
// Range table memory: start and last offset per entry, one write and one read port.
`timescale 1ns / 1ps
module barad_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [IDX_W-1:0]             waddr,
  input  logic [barad_pkg::ADDR_W-1:0] wstart,
  input  logic [barad_pkg::ADDR_W-1:0] wlast,
  input  logic                         re,
  input  logic [IDX_W-1:0]             raddr,
  output logic [barad_pkg::ADDR_W-1:0] rstart,
  output logic [barad_pkg::ADDR_W-1:0] rlast
);

  logic [barad_pkg::ADDR_W-1:0] start_mem [DEPTH];
  logic [barad_pkg::ADDR_W-1:0] last_mem  [DEPTH];

  // Write a new entry
  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wstart;
      last_mem[waddr]  <= wlast;
    end
  end

  // Registered read; hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rstart <= start_mem[raddr];
      rlast  <= last_mem[raddr];
    end
  end

endmodule

FILE: rtl/barad_cmp.sv
// Shared range compare unit: overlap test for attach, containment test for access.
`timescale 1ns / 1ps
module barad_cmp (
  input  logic                         attach,
  input  logic [barad_pkg::ADDR_W-1:0] addr,
  input  logic [barad_pkg::ADDR_W-1:0] addr_last,
  input  logic [barad_pkg::ADDR_W-1:0] ent_start,
  input  logic [barad_pkg::ADDR_W-1:0] ent_last,
  output barad_pkg::cmp_out_t          res
);

  logic [barad_pkg::ADDR_W:0]   fwd;
  logic [barad_pkg::ADDR_W-1:0] rev;
  logic                         ge;
  logic [barad_pkg::ADDR_W-1:0] mag;
  logic [barad_pkg::ADDR_W-1:0] lim;

  // Distance between the two starts, in whichever direction is non-negative
  always_comb begin
    fwd = {1'b0, addr} - {1'b0, ent_start};
    rev = ent_start - addr;
    ge  = ~fwd[barad_pkg::ADDR_W];
    mag = ge ? fwd[barad_pkg::ADDR_W-1:0] : rev;
    lim = ge ? ent_last : addr_last;
  end

  // An access below the entry start never hits; an attach checks both sides
  always_comb begin
    res.hit  = (mag <= lim) && (ge || attach);
    res.diff = fwd[barad_pkg::ADDR_W-1:0];
  end

endmodule

FILE: rtl/bus_address_range_decoder_unit.sv
// Scan: an item scans stored entries one per cycle through a single compare unit.
// A miss or a successful attach scans every stored entry, a hit or an overlap at entry k
// ends the scan there, and an attach to a full table returns without scanning.
// Throughput: one item at a time, next request taken the cycle after the result is made.
// Reset: rst (synchronous, active high) empties the table and drops any pending response.
`timescale 1ns / 1ps
module bus_address_range_decoder_unit #(
  parameter int MAX_RANGES = 16
) (
  input logic        clk,
  input logic        rst,
  barad_req_if.sink  req_ch,
  barad_rsp_if.source rsp_ch
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                         state;
  logic                         state_next;
  logic [CNT_W-1:0]             entry_count;
  logic [CNT_W-1:0]             rd_cnt;
  logic [CNT_W-1:0]             cmp_cnt;
  logic                         cmp_vld;

  logic                         item_cmd;
  logic [barad_pkg::ADDR_W-1:0] item_addr;
  logic [barad_pkg::ADDR_W-1:0] item_last;
  logic                         item_wr;
  logic [barad_pkg::DATA_W-1:0] item_wdata;

  logic                         rsp_valid;
  logic [barad_pkg::STAT_W-1:0] rsp_status;
  logic [barad_pkg::DEV_W-1:0]  rsp_dev;
  logic [barad_pkg::ADDR_W-1:0] rsp_offset;
  logic                         rsp_strobe;
  logic [barad_pkg::DATA_W-1:0] rsp_data;

  logic [barad_pkg::ADDR_W-1:0] ent_start;
  logic [barad_pkg::ADDR_W-1:0] ent_last;
  barad_pkg::cmp_out_t          cmp;

  logic accept;
  logic is_attach;
  logic full_att;
  logic hit_now;
  logic more;
  logic issue;
  logic done;
  logic out_free;
  logic finish;
  logic tbl_we;

  // Scan control
  always_comb begin
    accept    = (state == S_IDLE) && !rst && req_ch.valid;
    is_attach = (item_cmd == barad_pkg::CMD_ATTACH);
    full_att  = is_attach && (entry_count == MAX_CNT);
    hit_now   = cmp_vld && cmp.hit;
    more      = (rd_cnt < entry_count);
    issue     = (state == S_SCAN) && more && !hit_now && !full_att;
    done      = (state == S_SCAN) && (full_att || hit_now || !more);
    out_free  = !rsp_valid || rsp_ch.ready;
    finish    = done && out_free;
    tbl_we    = finish && is_attach && !full_att && !hit_now;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ch.ready = (state == S_IDLE) && !rst;

  barad_table #(
    .DEPTH (MAX_RANGES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (entry_count[IDX_W-1:0]),
    .wstart (item_addr),
    .wlast  (item_last),
    .re     (issue),
    .raddr  (rd_cnt[IDX_W-1:0]),
    .rstart (ent_start),
    .rlast  (ent_last)
  );

  barad_cmp u_cmp (
    .attach    (is_attach),
    .addr      (item_addr),
    .addr_last (item_last),
    .ent_start (ent_start),
    .ent_last  (ent_last),
    .res       (cmp)
  );

  // Sequencer state, scan counters and table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_cnt      <= '0;
      cmp_cnt     <= '0;
      cmp_vld     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_cnt  <= '0;
        cmp_vld <= 1'b0;
      end else if ((state == S_SCAN) && !done) begin
        cmp_vld <= issue;
        cmp_cnt <= rd_cnt;
        if (issue) rd_cnt <= rd_cnt + 1'b1;
      end
      if (tbl_we) entry_count <= entry_count + 1'b1;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= req_ch.cmd;
      item_addr  <= req_ch.address;
      item_last  <= req_ch.range_last;
      item_wr    <= req_ch.is_write;
      item_wdata <= req_ch.write_data;
    end
  end

  // Response valid: set on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_dev    <= '0;
      rsp_offset <= '0;
      rsp_strobe <= 1'b0;
      rsp_data   <= '0;
      if (full_att) begin
        rsp_status <= barad_pkg::STAT_FULL;
      end else if (hit_now && is_attach) begin
        rsp_status <= barad_pkg::STAT_OVERLAP;
        rsp_dev    <= barad_pkg::DEV_W'(cmp_cnt);
      end else if (hit_now) begin
        rsp_status <= barad_pkg::STAT_OK;
        rsp_dev    <= barad_pkg::DEV_W'(cmp_cnt);
        rsp_offset <= cmp.diff;
        rsp_strobe <= item_wr;
        rsp_data   <= item_wr ? item_wdata : '0;
      end else if (is_attach) begin
        rsp_status <= barad_pkg::STAT_OK;
        rsp_dev    <= barad_pkg::DEV_W'(entry_count);
      end else begin
        rsp_status <= barad_pkg::STAT_MISS;
      end
    end
  end

  assign rsp_ch.valid        = rsp_valid;
  assign rsp_ch.status       = rsp_status;
  assign rsp_ch.device_index = rsp_dev;
  assign rsp_ch.offset       = rsp_offset;
  assign rsp_ch.write_strobe = rsp_strobe;
  assign rsp_ch.data_out     = rsp_data;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= MAX_CNT)
    else $error("entry count above table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_cnt <= entry_count))
    else $error("scan index passed the fill count");

  a_attach_grows: assert property (@(posedge clk) disable iff (rst)
    tbl_we |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("successful attach did not append an entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == barad_pkg::STAT_FULL)) |-> (entry_count == MAX_CNT))
    else $error("table full reported with free entries");
`endif

endmodule

FILE: tb/sv/bus_address_range_decoder_unit_tb.sv
// Self-checking testbench for the bus address range decoder: directed and random requests.
`timescale 1ns / 1ps
module bus_address_range_decoder_unit_tb;

  localparam int          TABLE_DEPTH  = 16;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam logic [barad_pkg::ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [barad_pkg::ADDR_W-1:0] TOP_BASE = 64'hFFFF_FFFF_FFFF_FF00;

  typedef struct packed {
    logic                         cmd;
    logic [barad_pkg::ADDR_W-1:0] address;
    logic [barad_pkg::ADDR_W-1:0] range_last;
    logic                         is_write;
    logic [barad_pkg::DATA_W-1:0] write_data;
  } decode_req_t;

  typedef struct packed {
    logic [barad_pkg::STAT_W-1:0] status;
    logic [barad_pkg::DEV_W-1:0]  device_index;
    logic [barad_pkg::ADDR_W-1:0] offset;
    logic                         write_strobe;
    logic [barad_pkg::DATA_W-1:0] data_out;
  } decode_rsp_t;

  logic clk;
  logic rst;

  barad_req_if req_ch ();
  barad_rsp_if rsp_ch ();

  bus_address_range_decoder_unit #(
    .MAX_RANGES(TABLE_DEPTH)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .req_ch(req_ch),
    .rsp_ch(rsp_ch)
  );

  // Mirror of the range table, updated as each request is accepted
  logic [barad_pkg::ADDR_W-1:0] range_base [TABLE_DEPTH];
  logic [barad_pkg::ADDR_W-1:0] range_span [TABLE_DEPTH];
  int unsigned       range_count = 0;

  decode_rsp_t expected_decodes[$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Sender burst state and address slots taken by fresh ranges
  int unsigned burst_left = 0;
  bit          sender_gapless = 0;
  bit          slot_used [64];

  // Receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the response to one request and update the table mirror
  function automatic decode_rsp_t predict_decode(input decode_req_t r);
    decode_rsp_t res;
    int unsigned n;
    int unsigned i;
    bit          done;
    logic [barad_pkg::ADDR_W-1:0] sb;
    logic [barad_pkg::ADDR_W-1:0] lb;
    res  = '0;
    n    = range_count;
    done = 1'b0;
    if (r.cmd == barad_pkg::CMD_ATTACH) begin
      if (n >= TABLE_DEPTH) begin
        res.status = barad_pkg::STAT_FULL;
      end else begin
        for (i = 0; i < n && !done; i++) begin
          sb = range_base[i];
          lb = range_span[i];
          if ((r.address >= sb) ? (r.address - sb <= lb) : (sb - r.address <= r.range_last)) begin
            res.status       = barad_pkg::STAT_OVERLAP;
            res.device_index = 4'(i);
            done             = 1'b1;
          end
        end
        if (!done) begin
          range_base[n]    = r.address;
          range_span[n]    = r.range_last;
          range_count      = n + 1;
          res.status       = barad_pkg::STAT_OK;
          res.device_index = 4'(n);
        end
      end
    end else begin
      res.status = barad_pkg::STAT_MISS;
      for (i = 0; i < n && !done; i++) begin
        sb = range_base[i];
        if (r.address >= sb && r.address - sb <= range_span[i]) begin
          res.status       = barad_pkg::STAT_OK;
          res.device_index = 4'(i);
          res.offset       = r.address - sb;
          res.write_strobe = r.is_write;
          res.data_out     = r.is_write ? r.write_data : '0;
          done             = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [barad_pkg::ADDR_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Pick an address inside stored entry k, with the end clamped at the top of memory
  function automatic logic [barad_pkg::ADDR_W-1:0] pick_inside(input int unsigned k);
    logic [barad_pkg::ADDR_W-1:0] lim;
    logic [barad_pkg::ADDR_W-1:0] off;
    lim = (range_span[k] < ~range_base[k]) ? range_span[k] : ~range_base[k];
    case ($urandom_range(0, 3))
      0: off = '0;
      1: off = lim;
      2: off = (lim == ADDR_MAX) ? rand_word() : rand_word() % (lim + 1);
      default: off = (lim < 16) ? lim : 64'($urandom_range(0, 15));
    endcase
    return range_base[k] + off;
  endfunction

  // Drive one request in the current burst and predict its response on accept
  task automatic send_request(input logic cmd, input logic [barad_pkg::ADDR_W-1:0] address,
                              input logic [barad_pkg::ADDR_W-1:0] range_last,
                              input logic is_write,
                              input logic [barad_pkg::DATA_W-1:0] write_data);
    int unsigned gap;
    int unsigned pick;
    decode_req_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (sender_gapless || pick < 3) gap = 0;
      else if (pick < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 20);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.address    <= address;
    req_ch.range_last <= range_last;
    req_ch.is_write   <= is_write;
    req_ch.write_data <= write_data;
    do @(posedge clk); while (!req_ch.ready);
    r.cmd        = cmd;
    r.address    = address;
    r.range_last = range_last;
    r.is_write   = is_write;
    r.write_data = write_data;
    expected_decodes.push_back(predict_decode(r));
  endtask

  // Attach a range in an unused 2^58 slot, so it never overlaps another fresh range
  task automatic attach_fresh_range();
    int unsigned k;
    logic [barad_pkg::ADDR_W-1:0] span;
    do k = $urandom_range(1, 62); while (slot_used[k]);
    slot_used[k] = 1'b1;
    case ($urandom_range(0, 2))
      0: span = '0;
      1: span = 64'($urandom_range(1, 255));
      default: span = rand_word() & 64'h0003_FFFF_FFFF_FFFF;
    endcase
    send_request(barad_pkg::CMD_ATTACH,
                 (64'(k) << 58) + (rand_word() & 64'h0000_00FF_FFFF_FFFF),
                 span, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_empty_table();
    send_request(barad_pkg::CMD_ACCESS, '0, ADDR_MAX, 1'b0, 8'hFF);
    send_request(barad_pkg::CMD_ACCESS, ADDR_MAX, '0, 1'b1, 8'hFF);
  endtask

  task automatic test_attach_and_hit();
    send_request(barad_pkg::CMD_ATTACH, '0, '0, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ACCESS, '0, '0, 1'b1, 8'hA5);
    send_request(barad_pkg::CMD_ACCESS, 64'h1, '0, 1'b0, 8'h5A);
    send_request(barad_pkg::CMD_ATTACH, 64'h1000, 64'hFFF, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ATTACH, 64'h3000, 64'hFF, 1'b1, 8'hFF);
  endtask

  // Refused attaches report the first overlapping entry; touching ranges are fine
  task automatic test_overlap();
    send_request(barad_pkg::CMD_ATTACH, 64'h1800, 64'h10, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ATTACH, 64'h1FFF, 64'h1001, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ATTACH, '0, ADDR_MAX, 1'b1, 8'hFF);
    send_request(barad_pkg::CMD_ATTACH, 64'h2000, 64'hFFF, 1'b0, 8'h00);
  endtask

  // A range reaching past the top of memory ends there and does not wrap to zero
  task automatic test_saturated_end();
    send_request(barad_pkg::CMD_ATTACH, TOP_BASE, ADDR_MAX, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ACCESS, ADDR_MAX, '0, 1'b1, 8'h00);
    send_request(barad_pkg::CMD_ACCESS, TOP_BASE - 1, '0, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ATTACH, ADDR_MAX, '0, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ACCESS, '0, ADDR_MAX, 1'b0, 8'hFF);
  endtask

  task automatic test_range_edges();
    send_request(barad_pkg::CMD_ACCESS, 64'h1FFF, '0, 1'b1, 8'hFF);
    send_request(barad_pkg::CMD_ACCESS, 64'h2FFF, '0, 1'b1, 8'h01);
    send_request(barad_pkg::CMD_ACCESS, 64'h30FF, '0, 1'b0, 8'h80);
    send_request(barad_pkg::CMD_ACCESS, 64'h3100, '0, 1'b1, 8'h7F);
    send_request(barad_pkg::CMD_ACCESS, 64'h0FFF, '0, 1'b1, 8'h55);
  endtask

  // Mostly hits and refused attaches on the live table; it grows now and then until full
  task automatic test_random_traffic();
    int unsigned idx;
    int unsigned k;
    int unsigned d;
    bit          grow_pending;
    logic [barad_pkg::ADDR_W-1:0] a;
    logic [barad_pkg::ADDR_W-1:0] e;
    grow_pending = 1'b0;
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      sender_gapless = (idx >= 500 && idx < 700);
      if (idx % 100 == 50) grow_pending = 1'b1;
      k = $urandom_range(0, range_count - 1);
      if ($urandom_range(0, 3) == 0) begin
        if (grow_pending && range_count < TABLE_DEPTH) begin
          attach_fresh_range();
          grow_pending = 1'b0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              a = pick_inside(k);
              case ($urandom_range(0, 2))
                0: e = '0;
                1: e = 64'($urandom_range(0, 255));
                default: e = rand_word();
              endcase
            end
            5, 6: begin
              // Start below the entry and reach just into it, or start inside it near address zero
              d = $urandom_range(1, 16);
              if (range_base[k] >= 16) begin
                a = range_base[k] - 64'(d);
                e = 64'(d) + 64'($urandom_range(0, 3));
              end else begin
                a = pick_inside(k);
                e = 64'(d);
              end
            end
            default: begin
              // Noise: reaches the top of memory, so it always hits some entry
              a = rand_word();
              e = ~a | rand_word();
            end
          endcase
          send_request(barad_pkg::CMD_ATTACH, a, e, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: a = pick_inside(k);
          6: a = range_base[k] - 1;
          7: a = pick_inside(k) | 64'(0);
          8: a = rand_word();
          default: a = $urandom_range(0, 1) ? ADDR_MAX : '0;
        endcase
        if (a == range_base[k] + range_span[k] && $urandom_range(0, 1)) a = a + 1;
        send_request(barad_pkg::CMD_ACCESS, a, rand_word(), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
      end
    end
    sender_gapless = 1'b0;
  endtask

  // Fill the table, then check that the full status wins over overlap
  task automatic test_table_full();
    int unsigned k;
    while (range_count < TABLE_DEPTH) attach_fresh_range();
    attach_fresh_range();
    send_request(barad_pkg::CMD_ATTACH, '0, '0, 1'b0, 8'h00);
    send_request(barad_pkg::CMD_ATTACH, 64'h5000, 64'h10, 1'b1, 8'hFF);
    for (k = 0; k < TABLE_DEPTH; k++) begin
      send_request(barad_pkg::CMD_ACCESS, range_base[k], rand_word(), k[0],
                   8'($urandom_range(0, 255)));
    end
  endtask

  task automatic check_field(input string name, input logic [barad_pkg::ADDR_W-1:0] want,
                             input logic [barad_pkg::ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    decode_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_decodes.size() == 0) begin
        $error("response with no request outstanding: status %0d index %0d",
               rsp_ch.status, rsp_ch.device_index);
        fail_count++;
      end else begin
        want = expected_decodes.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_ch.status));
        check_field("device_index", 64'(want.device_index), 64'(rsp_ch.device_index));
        check_field("offset", want.offset, rsp_ch.offset);
        check_field("write_strobe", 64'(want.write_strobe), 64'(rsp_ch.write_strobe));
        check_field("data_out", 64'(want.data_out), 64'(rsp_ch.data_out));
      end
    end
  end

  // Stall the response side with a mode that is redrawn when its random hold count runs out
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(20, 150);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ch.ready <= (stall_phase < 2);
    endcase
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = barad_pkg::CMD_ATTACH;
    req_ch.address    = '0;
    req_ch.range_last = '0;
    req_ch.is_write   = 1'b0;
    req_ch.write_data = '0;
    slot_used         = '{default: 1'b0};
    // Directed ranges sit in the lowest and highest slots
    slot_used[0]      = 1'b1;
    slot_used[63]     = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_attach_and_hit();
    test_overlap();
    test_saturated_end();
    test_range_edges();
    test_random_traffic();
    test_table_full();

    // Drop valid and drain outstanding responses
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/barad_pkg.sv
rtl/barad_req_if.sv
rtl/barad_table.sv
rtl/barad_cmp.sv
rtl/bus_address_range_decoder_unit.sv
tb/sv/bus_address_range_decoder_unit_tb.sv
